FILE: rtl/pfp_pkg.sv
`timescale 1ns / 1ps

package pfp_pkg;

	// Received frame layout
	localparam int unsigned FRAME_LEN  = 12;
	localparam int unsigned SPAN_BASE  = 4;
	localparam int unsigned SPAN_LIMIT = 10;
	localparam int unsigned POS_LEN    = 3;
	localparam int unsigned POS_ID_LO  = 4;
	localparam int unsigned POS_ID_HI  = 5;
	localparam int unsigned POS_VAL0   = 6;
	localparam int unsigned POS_VAL1   = 7;
	localparam int unsigned POS_VAL2   = 8;
	localparam int unsigned POS_VAL3   = 9;
	localparam int unsigned POS_SUM    = 10;
	localparam int unsigned POS_SUM2   = 11;

	// Acknowledge frame layout
	localparam int unsigned ACK_LEN         = 9;
	localparam logic [7:0]  ACK_PAYLOAD_LEN = 8'd3;

	localparam logic [3:0] ACK_IDX_HEAD  = 4'd0;
	localparam logic [3:0] ACK_IDX_ADDR  = 4'd1;
	localparam logic [3:0] ACK_IDX_FID   = 4'd2;
	localparam logic [3:0] ACK_IDX_LEN   = 4'd3;
	localparam logic [3:0] ACK_IDX_WCODE = 4'd4;
	localparam logic [3:0] ACK_IDX_SUM_E = 4'd5;
	localparam logic [3:0] ACK_IDX_SS_E  = 4'd6;
	localparam logic [3:0] ACK_IDX_SUM   = 4'd7;
	localparam logic [3:0] ACK_IDX_SS    = 4'd8;

	// Configuration register indexes
	localparam logic [7:0] REG_FRAME_HEAD     = 8'd0;
	localparam logic [7:0] REG_DEVICE_ADDRESS = 8'd1;
	localparam logic [7:0] REG_ACK_FRAME_ID   = 8'd2;
	localparam logic [7:0] REG_WRITE_CODE     = 8'd3;

	localparam logic [7:0] FRAME_HEAD_RST = 8'd170;

	// Configuration values shared by the front and back parts
	typedef struct packed {
		logic [7:0] frame_head;
		logic [7:0] device_address;
		logic [7:0] ack_frame_id;
		logic [7:0] write_code;
	} cfg_t;

	// One accepted frame, handed from the front to the back
	typedef struct packed {
		logic [15:0]        param_id;
		logic signed [31:0] param_value;
		logic [7:0]         rx_sum;
		logic [7:0]         rx_sum2;
	} ack_req_t;

endpackage

FILE: rtl/pfp_front.sv
`timescale 1ns / 1ps

module pfp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        frame_head,
	input  logic              q_full,
	output logic              in_ready,
	output logic              push,
	output pfp_pkg::ack_req_t push_data
);

	logic [7:0] fb_q [pfp_pkg::FRAME_LEN];
	logic [3:0] cnt_q;
	logic [7:0] sum_q;
	logic [7:0] ss_q;

	logic       acc;
	logic       take;
	logic       in_span;
	logic [8:0] span;
	logic [7:0] sum_nx;
	logic [7:0] ss_nx;
	logic       last_pos;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	// A byte other than the head at the first position is dropped.
	assign take     = acc && !(cnt_q == 4'd0 && in_byte != frame_head);
	assign last_pos = (cnt_q == 4'(pfp_pkg::POS_SUM2));

	// Checksum span: the first four bytes always count, then positions below both length+4 and ten.
	assign span = {1'b0, fb_q[pfp_pkg::POS_LEN]} + 9'(pfp_pkg::SPAN_BASE);
	always_comb begin
		if (cnt_q < 4'(pfp_pkg::SPAN_BASE)) begin
			in_span = 1'b1;
		end else if (cnt_q < 4'(pfp_pkg::SPAN_LIMIT)) begin
			in_span = ({5'd0, cnt_q} < span);
		end else begin
			in_span = 1'b0;
		end
	end

	assign sum_nx = sum_q + in_byte;
	assign ss_nx  = ss_q + sum_nx;

	// Frame byte store, no reset needed.
	always_ff @(posedge clk) begin
		if (take) begin
			fb_q[cnt_q] <= in_byte;
		end
	end

	// Byte position and running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
			sum_q <= 8'd0;
			ss_q  <= 8'd0;
		end else if (take) begin
			if (last_pos) begin
				cnt_q <= 4'd0;
				sum_q <= 8'd0;
				ss_q  <= 8'd0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
				if (in_span) begin
					sum_q <= sum_nx;
					ss_q  <= ss_nx;
				end
			end
		end
	end

	// On the last byte the sums are final; the last byte is the second checksum.
	assign push = take && last_pos && (sum_q == fb_q[pfp_pkg::POS_SUM]) &&
		(ss_q == in_byte);

	assign push_data.param_id    = {fb_q[pfp_pkg::POS_ID_HI], fb_q[pfp_pkg::POS_ID_LO]};
	assign push_data.param_value = {fb_q[pfp_pkg::POS_VAL3], fb_q[pfp_pkg::POS_VAL2],
		fb_q[pfp_pkg::POS_VAL1], fb_q[pfp_pkg::POS_VAL0]};
	assign push_data.rx_sum      = fb_q[pfp_pkg::POS_SUM];
	assign push_data.rx_sum2     = in_byte;

endmodule

FILE: rtl/pfp_queue.sv
`timescale 1ns / 1ps

module pfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pfp_pkg::ack_req_t push_data,
	input  logic              pop,
	output logic              full,
	output logic              head_valid,
	output pfp_pkg::ack_req_t head_data
);

	pfp_pkg::ack_req_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_data  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/pfp_back.sv
`timescale 1ns / 1ps

module pfp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pfp_pkg::cfg_t      cfg,
	input  logic               head_valid,
	input  pfp_pkg::ack_req_t  head_data,
	output logic               pop,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [7:0]         out_byte,
	output logic               out_last,
	output logic [15:0]        out_id,
	output logic signed [31:0] out_value
);

	logic [3:0] idx_q;
	logic [7:0] sum_q;
	logic [7:0] ss_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [15:0] id_q;
	logic signed [31:0] val_q;

	logic       load;
	logic       at_last;
	logic [7:0] nx_byte;
	logic [7:0] sum_nx;
	logic [7:0] ss_nx;

	assign load    = head_valid && (!valid_q || out_ready);
	assign at_last = (idx_q == pfp_pkg::ACK_IDX_SS);
	assign pop     = load && at_last;

	// Select the acknowledge byte for the current position.
	always_comb begin
		case (idx_q)
			pfp_pkg::ACK_IDX_HEAD:  nx_byte = cfg.frame_head;
			pfp_pkg::ACK_IDX_ADDR:  nx_byte = cfg.device_address;
			pfp_pkg::ACK_IDX_FID:   nx_byte = cfg.ack_frame_id;
			pfp_pkg::ACK_IDX_LEN:   nx_byte = pfp_pkg::ACK_PAYLOAD_LEN;
			pfp_pkg::ACK_IDX_WCODE: nx_byte = cfg.write_code;
			pfp_pkg::ACK_IDX_SUM_E: nx_byte = head_data.rx_sum;
			pfp_pkg::ACK_IDX_SS_E:  nx_byte = head_data.rx_sum2;
			pfp_pkg::ACK_IDX_SUM:   nx_byte = sum_q;
			pfp_pkg::ACK_IDX_SS:    nx_byte = ss_q;
			default:                nx_byte = 8'd0;
		endcase
	end

	// Running checksums restart at the head byte.
	assign sum_nx = ((idx_q == pfp_pkg::ACK_IDX_HEAD) ? 8'd0 : sum_q) + nx_byte;
	assign ss_nx  = ((idx_q == pfp_pkg::ACK_IDX_HEAD) ? 8'd0 : ss_q) + sum_nx;

	// Sequencer position and checksums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= pfp_pkg::ACK_IDX_HEAD;
			sum_q   <= 8'd0;
			ss_q    <= 8'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_last ? pfp_pkg::ACK_IDX_HEAD : idx_q + 4'd1;
				if (idx_q < pfp_pkg::ACK_IDX_SUM) begin
					sum_q <= sum_nx;
					ss_q  <= ss_nx;
				end
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nx_byte;
			last_q <= at_last;
			id_q   <= head_data.param_id;
			val_q  <= head_data.param_value;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_id    = id_q;
	assign out_value = val_q;

endmodule

FILE: rtl/param_frame_parser_with_ack_unit.sv
`timescale 1ns / 1ps
// Output path: after the twelfth frame byte is accepted, the frame is written to the queue and
// its first acknowledge byte is then loaded into the output register that drives m_tvalid.
// Throughput: one received byte per cycle in, stalled only while the queue holds two frames;
// one acknowledge byte per cycle out while m_tready is high, nine per accepted frame.
// Reset (arst_n low, asynchronous) clears the count, sums, queue and output valid,
// and returns the registers to head 170 and zero elsewhere.

module param_frame_parser_with_ack_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] ack_byte, [23:8] param_id, [55:24] param_value
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	pfp_pkg::cfg_t     cfg_q;
	pfp_pkg::ack_req_t push_data;
	pfp_pkg::ack_req_t head_data;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              head_valid;
	logic [7:0]        ack_byte;
	logic [15:0]       param_id;
	logic signed [31:0] param_value;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_head     <= pfp_pkg::FRAME_HEAD_RST;
			cfg_q.device_address <= 8'd0;
			cfg_q.ack_frame_id   <= 8'd0;
			cfg_q.write_code     <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pfp_pkg::REG_FRAME_HEAD:     cfg_q.frame_head     <= cfg_data;
				pfp_pkg::REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data;
				pfp_pkg::REG_ACK_FRAME_ID:   cfg_q.ack_frame_id   <= cfg_data;
				pfp_pkg::REG_WRITE_CODE:     cfg_q.write_code     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: frame assembly and checksum test.
	pfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.frame_head (cfg_q.frame_head),
		.q_full     (q_full),
		.in_ready   (s_tready),
		.push       (push),
		.push_data  (push_data)
	);

	// Queue of accepted frames.
	pfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// Back: acknowledge frame sequencer.
	pfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_byte   (ack_byte),
		.out_last   (m_tlast),
		.out_id     (param_id),
		.out_value  (param_value)
	);

	assign m_tdata = {param_value, param_id, ack_byte};

endmodule

FILE: verif/param_frame_parser_with_ack_unit_tb.sv
`timescale 1ns / 1ps

module param_frame_parser_with_ack_unit_tb;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned PHASE_BYTES  = 50;
	localparam logic [7:0]  REG_FIRST_UNUSED = pfp_pkg::REG_WRITE_CODE + 8'd1;
	localparam logic [7:0]  REG_LAST_INDEX   = 8'hFF;

	typedef enum int unsigned {
		FRAME_GOOD,
		FRAME_BAD_SUM,
		FRAME_BAD_SUM2
	} frame_kind_t;

	typedef logic [7:0] frame_t [pfp_pkg::FRAME_LEN];

	// One acknowledge byte together with the parameter it carries
	typedef struct packed {
		logic [7:0]         ack_byte;
		logic               last;
		logic [15:0]        param_id;
		logic signed [31:0] param_value;
	} ack_beat_t;

	// Mirrors the parser and holds the acknowledge bytes still owed by the block.
	class ack_scoreboard;
		pfp_pkg::cfg_t regs;
		logic [7:0]  rx_frame [pfp_pkg::FRAME_LEN];
		int unsigned rx_count;
		logic [7:0]  run_sum;
		logic [7:0]  run_sum2;
		ack_beat_t   ack_due [$];
		int unsigned errors;
		int unsigned frames_good;
		int unsigned frames_bad;
		int unsigned beats_checked;

		function new();
			regs.frame_head     = pfp_pkg::FRAME_HEAD_RST;
			regs.device_address = 8'd0;
			regs.ack_frame_id   = 8'd0;
			regs.write_code     = 8'd0;
			rx_count      = 0;
			run_sum       = 8'd0;
			run_sum2      = 8'd0;
			errors        = 0;
			frames_good   = 0;
			frames_bad    = 0;
			beats_checked = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [7:0] val);
			case (idx)
			pfp_pkg::REG_FRAME_HEAD:     regs.frame_head = val;
			pfp_pkg::REG_DEVICE_ADDRESS: regs.device_address = val;
			pfp_pkg::REG_ACK_FRAME_ID:   regs.ack_frame_id = val;
			pfp_pkg::REG_WRITE_CODE:     regs.write_code = val;
			default: ;
			endcase
		endfunction

		function bit at_frame_start();
			return rx_count == 0;
		endfunction

		// Takes one received byte and queues the acknowledge when a frame passes.
		function void take_rx_byte(logic [7:0] b);
			logic [7:0]  ack [pfp_pkg::ACK_LEN];
			logic [7:0]  s;
			logic [7:0]  ss;
			int unsigned pos;
			bit          pass;
			ack_beat_t   beat;
			pos = rx_count;
			if (pos == 0 && b != regs.frame_head)
				return;
			rx_frame[pos] = b;
			// Bytes past length+4 or past the span limit do not enter the sums
			if (pos < pfp_pkg::SPAN_BASE || (pos < pfp_pkg::SPAN_LIMIT &&
				pos < rx_frame[pfp_pkg::POS_LEN] + pfp_pkg::SPAN_BASE)) begin
				run_sum  = run_sum + b;
				run_sum2 = run_sum2 + run_sum;
			end
			rx_count = pos + 1;
			if (rx_count < pfp_pkg::FRAME_LEN)
				return;
			pass = (run_sum == rx_frame[pfp_pkg::POS_SUM]) &&
				(run_sum2 == rx_frame[pfp_pkg::POS_SUM2]);
			rx_count = 0;
			run_sum  = 8'd0;
			run_sum2 = 8'd0;
			if (!pass) begin
				frames_bad++;
				return;
			end
			frames_good++;
			ack[pfp_pkg::ACK_IDX_HEAD]  = regs.frame_head;
			ack[pfp_pkg::ACK_IDX_ADDR]  = regs.device_address;
			ack[pfp_pkg::ACK_IDX_FID]   = regs.ack_frame_id;
			ack[pfp_pkg::ACK_IDX_LEN]   = pfp_pkg::ACK_PAYLOAD_LEN;
			ack[pfp_pkg::ACK_IDX_WCODE] = regs.write_code;
			ack[pfp_pkg::ACK_IDX_SUM_E] = rx_frame[pfp_pkg::POS_SUM];
			ack[pfp_pkg::ACK_IDX_SS_E]  = rx_frame[pfp_pkg::POS_SUM2];
			s  = 8'd0;
			ss = 8'd0;
			for (int k = 0; k < pfp_pkg::ACK_IDX_SUM; k++) begin
				s  = s + ack[k];
				ss = ss + s;
			end
			ack[pfp_pkg::ACK_IDX_SUM] = s;
			ack[pfp_pkg::ACK_IDX_SS]  = ss;
			for (int k = 0; k < pfp_pkg::ACK_LEN; k++) begin
				beat.ack_byte    = ack[k];
				beat.last        = (k == pfp_pkg::ACK_LEN - 1);
				beat.param_id    = {rx_frame[pfp_pkg::POS_ID_HI], rx_frame[pfp_pkg::POS_ID_LO]};
				beat.param_value = {rx_frame[pfp_pkg::POS_VAL3], rx_frame[pfp_pkg::POS_VAL2],
					rx_frame[pfp_pkg::POS_VAL1], rx_frame[pfp_pkg::POS_VAL0]};
				ack_due.push_back(beat);
			end
		endfunction

		// Compares one acknowledge transaction with the oldest byte owed.
		function void check_ack_beat(logic [55:0] data, logic last);
			ack_beat_t want;
			ack_beat_t got;
			got.ack_byte    = data[7:0];
			got.last        = last;
			got.param_id    = data[23:8];
			got.param_value = data[55:24];
			beats_checked++;
			if (ack_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected acknowledge byte, expected none, actual %02h",
					$time, got.ack_byte);
				return;
			end
			want = ack_due.pop_front();
			if (got.ack_byte !== want.ack_byte) begin
				errors++;
				$display("%0t: ack_byte mismatch, expected %02h, actual %02h",
					$time, want.ack_byte, got.ack_byte);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: tlast mismatch, expected %0b, actual %0b",
					$time, want.last, got.last);
			end
			if (got.param_id !== want.param_id) begin
				errors++;
				$display("%0t: param_id mismatch, expected %04h, actual %04h",
					$time, want.param_id, got.param_id);
			end
			if (got.param_value !== want.param_value) begin
				errors++;
				$display("%0t: param_value mismatch, expected %0d, actual %0d",
					$time, want.param_value, got.param_value);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [7:0]  cfg_data;

	ack_scoreboard sb = new();

	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned rx_hold_req;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	int unsigned bytes_sent;

	param_frame_parser_with_ack_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver readiness; a requested hold-off is counted down here.
	always @(negedge clk) begin
		if (rx_hold_req != 0) begin
			hold_left   = rx_hold_req;
			rx_hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Acknowledge checking and the watchdog on transactions of any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_ack_beat(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("param_frame_parser_with_ack_unit_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		do @(posedge clk); while (!s_tready);
		sb.take_rx_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_part(input frame_t f, input int unsigned from, input int unsigned upto);
		for (int unsigned p = from; p < upto; p++)
			send_byte(f[p]);
	endtask

	// Stops sending until every owed acknowledge byte has come out.
	task automatic wait_acks();
		s_tvalid = 1'b0;
		while (sb.ack_due.size() != 0)
			@(negedge clk);
	endtask

	// Leaves the block idle so that a register can be written.
	task automatic settle();
		wait_acks();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Builds a frame with correct sums over its span, then spoils one if asked.
	function automatic frame_t build_frame(input logic [7:0] head, input logic [7:0] len,
		input logic [15:0] pid, input logic [31:0] pval, input frame_kind_t kind);
		frame_t      f;
		logic [7:0]  s;
		logic [7:0]  ss;
		int unsigned span;
		f[0]                  = head;
		f[1]                  = 8'($urandom);
		f[2]                  = 8'($urandom);
		f[pfp_pkg::POS_LEN]   = len;
		f[pfp_pkg::POS_ID_LO] = pid[7:0];
		f[pfp_pkg::POS_ID_HI] = pid[15:8];
		f[pfp_pkg::POS_VAL0]  = pval[7:0];
		f[pfp_pkg::POS_VAL1]  = pval[15:8];
		f[pfp_pkg::POS_VAL2]  = pval[23:16];
		f[pfp_pkg::POS_VAL3]  = pval[31:24];
		span = (len + pfp_pkg::SPAN_BASE > pfp_pkg::SPAN_LIMIT) ? pfp_pkg::SPAN_LIMIT :
			len + pfp_pkg::SPAN_BASE;
		s  = 8'd0;
		ss = 8'd0;
		for (int unsigned p = 0; p < span; p++) begin
			s  = s + f[p];
			ss = ss + s;
		end
		f[pfp_pkg::POS_SUM]  = s;
		f[pfp_pkg::POS_SUM2] = ss;
		if (kind == FRAME_BAD_SUM)
			f[pfp_pkg::POS_SUM] = s ^ 8'($urandom_range(255, 1));
		else if (kind == FRAME_BAD_SUM2)
			f[pfp_pkg::POS_SUM2] = ss ^ 8'($urandom_range(255, 1));
		return f;
	endfunction

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic send_random_frame(input frame_kind_t kind);
		logic [7:0]  len;
		logic [15:0] pid;
		logic [31:0] pval;
		len  = ($urandom_range(99) < 60) ? 8'($urandom_range(6)) : 8'($urandom);
		pid  = ($urandom_range(9) == 0) ? {2{pick_byte()}} : 16'($urandom);
		pval = ($urandom_range(9) == 0) ? {4{pick_byte()}} : 32'($urandom);
		send_part(build_frame(sb.regs.frame_head, len, pid, pval, kind), 0,
			pfp_pkg::FRAME_LEN);
	endtask

	// A stray byte between frames; it never matches the head so it is dropped.
	task automatic send_noise();
		logic [7:0] b;
		b = 8'($urandom);
		if (sb.at_frame_start() && b == sb.regs.frame_head)
			b = ~b;
		send_byte(b);
	endtask

	task automatic write_random_regs();
		write_reg(pfp_pkg::REG_FRAME_HEAD, pick_byte());
		write_reg(pfp_pkg::REG_DEVICE_ADDRESS, pick_byte());
		write_reg(pfp_pkg::REG_ACK_FRAME_ID, pick_byte());
		write_reg(pfp_pkg::REG_WRITE_CODE, pick_byte());
		write_reg(8'($urandom_range(REG_LAST_INDEX, REG_FIRST_UNUSED)), 8'($urandom));
	endtask

	// Mostly good frames, with checksum failures, stray bytes and sender pauses mixed in.
	task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct);
		int unsigned start;
		int unsigned pick;
		write_random_regs();
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 70)
				send_random_frame(FRAME_GOOD);
			else if (pick < 80)
				send_random_frame((pick % 2) ? FRAME_BAD_SUM : FRAME_BAD_SUM2);
			else if (pick < 95)
				send_noise();
			else
				wait_acks();
		end
		settle();
	endtask

	initial begin
		frame_t f;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'd0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = pfp_pkg::REG_FRAME_HEAD;
		cfg_data     = 8'd0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold_req  = 0;
		hold_left    = 0;
		quiet_cycles = 0;
		bytes_sent   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset registers: stray bytes, span edges, field extremes, checksum failures
		send_byte(8'h00);
		send_byte(8'hFF);
		send_part(build_frame(pfp_pkg::FRAME_HEAD_RST, 8'd0, 16'h0000, 32'h0000_0000,
			FRAME_GOOD), 0, pfp_pkg::FRAME_LEN);
		send_part(build_frame(pfp_pkg::FRAME_HEAD_RST, 8'd6, 16'hFFFF, 32'h7FFF_FFFF,
			FRAME_GOOD), 0, pfp_pkg::FRAME_LEN);
		send_part(build_frame(pfp_pkg::FRAME_HEAD_RST, 8'd7, 16'h0001, 32'h8000_0000,
			FRAME_GOOD), 0, pfp_pkg::FRAME_LEN);
		send_part(build_frame(pfp_pkg::FRAME_HEAD_RST, 8'd255, 16'h8000, 32'hFFFF_FFFF,
			FRAME_GOOD), 0, pfp_pkg::FRAME_LEN);
		send_part(build_frame(pfp_pkg::FRAME_HEAD_RST, 8'd2, 16'h1234, 32'h0000_0001,
			FRAME_BAD_SUM), 0, pfp_pkg::FRAME_LEN);
		send_part(build_frame(pfp_pkg::FRAME_HEAD_RST, 8'd3, 16'h4321, 32'h0123_4567,
			FRAME_BAD_SUM2), 0, pfp_pkg::FRAME_LEN);
		settle();

		// Register extremes, and writes to indexes that do not exist
		write_reg(pfp_pkg::REG_FRAME_HEAD, 8'h00);
		write_reg(pfp_pkg::REG_DEVICE_ADDRESS, 8'hFF);
		write_reg(pfp_pkg::REG_ACK_FRAME_ID, 8'hFF);
		write_reg(pfp_pkg::REG_WRITE_CODE, 8'hFF);
		write_reg(REG_FIRST_UNUSED, 8'h5A);
		write_reg(REG_LAST_INDEX, 8'hA5);
		send_byte(8'hFF);
		send_part(build_frame(8'h00, 8'd5, 16'hA5A5, 32'h5A5A_5A5A, FRAME_GOOD), 0,
			pfp_pkg::FRAME_LEN);
		settle();
		write_reg(pfp_pkg::REG_FRAME_HEAD, 8'hFF);
		write_reg(pfp_pkg::REG_DEVICE_ADDRESS, 8'h00);
		write_reg(pfp_pkg::REG_ACK_FRAME_ID, 8'h00);
		write_reg(pfp_pkg::REG_WRITE_CODE, 8'h00);
		send_byte(8'h00);

		// The head is only compared at the first byte, so changing it mid-frame keeps the frame
		f = build_frame(8'hFF, 8'd4, 16'h00FF, 32'hFF00_FF00, FRAME_GOOD);
		send_part(f, 0, 6);
		settle();
		write_reg(pfp_pkg::REG_FRAME_HEAD, 8'h55);
		send_part(f, 6, pfp_pkg::FRAME_LEN);
		send_byte(8'hFF);
		send_part(build_frame(8'h55, 8'd1, 16'h0102, 32'h0304_0506, FRAME_GOOD), 0,
			pfp_pkg::FRAME_LEN);
		settle();

		// Long receiver hold-off while good frames keep coming, to back up the input
		rx_hold_req = HOLD_CYCLES;
		repeat (6) send_random_frame(FRAME_GOOD);
		settle();

		// Random traffic under each idling pattern
		run_phase(0, 0);
		run_phase(76, 0);
		run_phase(0, 76);
		run_phase(23, 23);

		$display("Run covered %0d received bytes: %0d frames acknowledged, %0d dropped on checksum,",
			bytes_sent, sb.frames_good, sb.frames_bad);
		$display("%0d acknowledge bytes checked, across register extremes, idling and a hold-off.",
			sb.beats_checked);
		if (sb.errors == 0 && sb.ack_due.size() == 0)
			$display("param_frame_parser_with_ack_unit_tb: done, clean");
		else
			$display("param_frame_parser_with_ack_unit_tb: done, errors");
		$finish;
	end

endmodule
